// File: hw/rtl/sfcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared constants, types and helpers for the sync-byte frame deframer.
// ----------------------------------------------------------------------------
package sfcd_pkg;

   // frame geometry
   localparam int CHANNELS = 10;
   localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W    = $clog2(CHANNELS + 1);
   localparam int IDX_W    = 4;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] SUM_ALIAS = 8'hFF;

   // write port of the frame buffer
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   // read port of the frame buffer
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   // map a buffer address onto the 4-bit channel index (masked)
   function automatic logic [IDX_W-1:0] to_index(input logic [ADDR_W-1:0] a);
      logic [31:0] wide;
      wide = 32'(a);
      return wide[IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sync_frame_checksum_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sync_frame_checksum_deframer
// Collects a sync-led frame of channel bytes into a buffer, checks the
// additive checksum and replays the buffered values when it matches.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                   | word
//  req     | in        | req_valid req_ready req_rx_byte         | one byte
//  rsp     | out       | rsp_valid rsp_ready rsp_channel_index   | one value
//          |           | rsp_channel_value rsp_last_of_frame     |
//
//  A received byte is taken whenever offered while the block hunts or fills.
//  A matching checksum starts a replay of CHANNELS values; each value takes
//  a buffer read state, then an output load state, through the single read
//  port, one value at a time. req_ready is low during the replay.
//  Reset returns the block to sync hunt; buffer contents are not cleared.
//  A stalled rsp holds the replay on the current value.
// ----------------------------------------------------------------------------
module sync_frame_checksum_deframer
   import sfcd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_rx_byte,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [IDX_W-1:0]      rsp_channel_index,
   output logic [7:0]            rsp_channel_value,
   output logic                  rsp_last_of_frame
);

   typedef enum logic [3:0] {
      ST_HUNT = 4'b0001,
      ST_FILL = 4'b0010,
      ST_READ = 4'b0100,
      ST_LOAD = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        sum_ff, sum_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [7:0]        rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;

   ram_wr_type        ram_wr;
   ram_rd_type        ram_rd;
   logic [7:0]        ram_rd_data;
   logic              req_take;
   logic              rsp_free;
   logic [7:0]        expect_sum;
   logic              ptr_last;

   sfcd_frame_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

   assign req_ready  = (state_ff == ST_HUNT) || (state_ff == ST_FILL);
   assign req_take   = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign expect_sum = (sum_ff == SUM_ALIAS) ? 8'h00 : sum_ff;
   assign ptr_last   = (ptr_ff == ADDR_W'(CHANNELS - 1));

   // frame control, buffer access and output loading
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      ptr_in       = ptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr.en    = 1'b0;
      ram_wr.addr  = count_ff[ADDR_W-1:0];
      ram_wr.data  = req_rx_byte;
      ram_rd.en    = 1'b0;
      ram_rd.addr  = ptr_ff;

      unique case (state_ff)
         ST_HUNT: begin
            if (req_take && req_rx_byte == SYNC_BYTE) begin
               state_in = ST_FILL;
               count_in = '0;
               sum_in   = '0;
            end
         end
         ST_FILL: begin
            if (req_take) begin
               if (req_rx_byte == SYNC_BYTE) begin
                  // restart the frame
                  count_in = '0;
                  sum_in   = '0;
               end else if (count_ff != CNT_W'(CHANNELS)) begin
                  // store a value and accumulate
                  ram_wr.en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
                  sum_in    = sum_ff + req_rx_byte;
               end else begin
                  // checksum byte: replay on match, drop otherwise
                  count_in = '0;
                  sum_in   = '0;
                  ptr_in   = '0;
                  state_in = (req_rx_byte == expect_sum) ? ST_READ : ST_HUNT;
               end
            end
         end
         ST_READ: begin
            ram_rd.en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = to_index(ptr_ff);
               rsp_value_in = ram_rd_data;
               rsp_last_in  = ptr_last;
               if (ptr_last) begin
                  state_in = ST_HUNT;
               end else begin
                  ptr_in   = ptr_ff + ADDR_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HUNT;
         count_ff     <= '0;
         sum_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel_index = rsp_index_ff;
   assign rsp_channel_value = rsp_value_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule
`default_nettype wire

// File: hw/rtl/sfcd_frame_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfcd_frame_ram
// Frame value buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sfcd_frame_ram
   import sfcd_pkg::*;
(
   input  wire logic       clock,
   input  wire ram_wr_type wr,
   input  wire ram_rd_type rd,
   output logic [7:0]      rd_data
);

   logic [7:0] mem_ff [CHANNELS];

   // store a received value
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // read one entry; hold the data between reads
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= mem_ff[rd.addr];
      end
   end

endmodule
`default_nettype wire
